FILE: hw/rtl/ibpf_pkg.sv
// Shared types, constants and the axis mapping function for the border pad fetch block.
package ibpf_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_PAD    = 16;
    localparam int PIXEL_BITS = 32;

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IDX_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        PAD_FILL = 2'd0,
        PAD_REPL = 2'd1,
        PAD_REFL = 2'd2
    } pad_mode_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PAD    = 2'd2,
        REG_MODE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } axis_map_t;

    // Map one padded coordinate to an interior index; ok low means zero fill.
    function automatic axis_map_t map_axis(logic [7:0] c, logic [7:0] n, logic [4:0] p,
                                           logic [1:0] mode);
        logic [8:0] c9;
        logic [8:0] n9;
        logic [8:0] p9;
        logic [8:0] hi;
        logic [8:0] k;
        logic [8:0] x;
        axis_map_t  r;
        c9 = {1'b0, c};
        n9 = {1'b0, n};
        p9 = {4'd0, p};
        hi = p9 + n9;
        k  = p9 - 9'd1 - c9;
        x  = c9 - hi;
        r.ok  = 1'b1;
        r.idx = '0;
        if (c9 >= p9 && c9 < hi) begin
            r.idx = IDX_W'(c9 - p9);
        end else if (mode == PAD_FILL) begin
            r.ok = 1'b0;
        end else if (c9 < p9) begin
            if (mode == PAD_REPL) begin
                r.idx = '0;
            end else begin
                // mirror includes the edge; clamp to far edge past the image
                r.idx = (k >= n9) ? IDX_W'(n9 - 9'd1) : IDX_W'(k);
            end
        end else begin
            if (mode == PAD_REPL) begin
                r.idx = IDX_W'(n9 - 9'd1);
            end else begin
                r.idx = (x >= n9) ? '0 : IDX_W'(n9 - 9'd1 - x);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/image_border_pad_fetch.sv
// Top level: padded image plane fetch with an interior pixel store and APB configuration.
// Usage:
//   Input stream (s_*): one word per command. s_tuser is the command (write
//   interior pixel or read padded pixel); s_tdata carries column, row and pixel.
//   A write stores one pixel of the interior; a read names a coordinate of the
//   padded plane and returns the pixel the selected border mode places there.
//   Output stream (m_*): exactly one word per command, in order. m_tdata is the
//   pixel (zero on writes), m_tuser is the error flag.
//   Result: the result word is registered and appears in the cycle after the command is accepted.
//   Throughput: one command per cycle while the output is not stalled; the
//   mapping logic feeds the single port of the plane memory directly, and its
//   registered read data is the output word, so the memory port sets the rate.
//   Stall: while m_tvalid is high and m_tready low, the result holds and
//   s_tready drops; the next command is taken in the cycle the result leaves.
//   Reset: clears the handshake state and restores width 128, height 128,
//   pad 0 and zero fill. The plane memory is not cleared; a pixel reads back
//   only after it has been written.
//   Configuration: APB registers at 0x0 width, 0x4 height, 0x8 pad, 0xC mode.
//   The user writes them only while the block is idle; the block has no such check.
module image_border_pad_fetch (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // column [7:0], row [15:8], pixel_in [47:16]
    input  logic        s_tuser,   // cmd [0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_out [31:0]
    output logic        m_tuser    // status [0]
);
    import ibpf_pkg::*;

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [4:0] pad_reg;
    logic [1:0] mode_reg;

    logic       out_valid_reg;
    logic       status_reg;
    logic       zero_reg;
    logic       out_valid_next;
    logic       status_next;
    logic       zero_next;

    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rdata_reg;

    logic       cfg_wr;
    logic       accept;
    logic [7:0] col;
    logic [7:0] row;
    logic [31:0] pix;
    logic [7:0] w_eff;
    logic [7:0] h_eff;
    logic [4:0] p_eff;
    logic [8:0] col_lim;
    logic [8:0] row_lim;
    logic       wr_inside;
    logic       rd_inside;
    logic       mem_we;
    axis_map_t  cmap;
    axis_map_t  rmap;
    logic [ADDR_W-1:0] mem_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  prdata = {24'd0, width_reg};
            REG_HEIGHT: prdata = {24'd0, height_reg};
            REG_PAD:    prdata = {27'd0, pad_reg};
            REG_MODE:   prdata = {30'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            pad_reg    <= 5'd0;
            mode_reg   <= PAD_FILL;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_WIDTH:  width_reg  <= pwdata[7:0];
                REG_HEIGHT: height_reg <= pwdata[7:0];
                REG_PAD:    pad_reg    <= pwdata[4:0];
                REG_MODE:   mode_reg   <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    // Take a new word whenever the output slot is free or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign col = s_tdata[7:0];
    assign row = s_tdata[15:8];
    assign pix = s_tdata[47:16];

    // Effective sizes: a zero width or height acts as one, oversize saturates.
    always_comb
    begin
        if (width_reg == 8'd0)
            w_eff = 8'd1;
        else if ({24'd0, width_reg} > MAX_WIDTH)
            w_eff = 8'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 8'd0)
            h_eff = 8'd1;
        else if ({24'd0, height_reg} > MAX_HEIGHT)
            h_eff = 8'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        if ({27'd0, pad_reg} > MAX_PAD)
            p_eff = 5'(MAX_PAD);
        else
            p_eff = pad_reg;
    end

    assign col_lim   = {1'b0, w_eff} + {3'd0, p_eff, 1'b0};
    assign row_lim   = {1'b0, h_eff} + {3'd0, p_eff, 1'b0};
    assign wr_inside = (col < w_eff) && (row < h_eff);
    assign rd_inside = ({1'b0, col} < col_lim) && ({1'b0, row} < row_lim);

    assign cmap = map_axis(col, w_eff, p_eff, mode_reg);
    assign rmap = map_axis(row, h_eff, p_eff, mode_reg);

    always_comb
    begin
        if (cmd_t'(s_tuser) == CMD_WRITE)
            mem_addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
        else
            mem_addr = ADDR_W'(rmap.idx[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(cmap.idx[COL_W-1:0]);
    end

    assign mem_we = accept && (cmd_t'(s_tuser) == CMD_WRITE) && wr_inside;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= PIXEL_BITS'(pix);
    end

    // Read data holds while the result is stalled: the port reads only on accept.
    always_ff @(posedge clk)
    begin
        if (accept && (cmd_t'(s_tuser) == CMD_READ))
            rdata_reg <= mem[mem_addr];
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        zero_next      = zero_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (cmd_t'(s_tuser) == CMD_WRITE)
            begin
                status_next = !wr_inside;
                zero_next   = 1'b1;
            end
            else
            begin
                status_next = !rd_inside;
                zero_next   = !rd_inside || !cmap.ok || !rmap.ok;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            zero_reg      <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            zero_reg      <= zero_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = zero_reg ? 32'd0 : 32'(rdata_reg);
    assign m_tuser  = status_reg;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the padded image plane fetch block.
`timescale 1ns / 1ps

module tb;
    import ibpf_pkg::*;

    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [31:0] pixel;
        logic        status;
    } fetch_result_t;

    // Shadow of the pixel plane and registers; queues the expected result words.
    class pad_fetch_board;
        logic [31:0]   plane [DEPTH];
        bit            written [DEPTH];
        logic [7:0]    reg_width;
        logic [7:0]    reg_height;
        logic [4:0]    reg_pad;
        logic [1:0]    reg_mode;
        int            errors;
        fetch_result_t expected_q [$];

        function new();
            reg_width  = 8'd128;
            reg_height = 8'd128;
            reg_pad    = 5'd0;
            reg_mode   = PAD_FILL;
            errors     = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_WIDTH:  reg_width  = value[7:0];
                REG_HEIGHT: reg_height = value[7:0];
                REG_PAD:    reg_pad    = value[4:0];
                REG_MODE:   reg_mode   = value[1:0];
                default:    ;
            endcase
        endfunction

        function int interior_w();
            if (reg_width == 0) return 1;
            return (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
        endfunction

        function int interior_h();
            if (reg_height == 0) return 1;
            return (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
        endfunction

        function int border();
            return (reg_pad > MAX_PAD) ? MAX_PAD : int'(reg_pad);
        endfunction

        // Fold one padded coordinate onto the interior; zero return means zero fill.
        function bit fold(int c, int n, int p, output int idx);
            int k;
            idx = 0;
            if (c >= p && c < p + n) begin
                idx = c - p;
                return 1'b1;
            end
            if (reg_mode == PAD_FILL) return 1'b0;
            if (c < p) begin
                k = p - 1 - c;
                if (reg_mode == PAD_REPL) idx = 0;
                else idx = (k >= n) ? n - 1 : k;
            end else begin
                k = c - p - n;
                if (reg_mode == PAD_REPL) idx = n - 1;
                else idx = (k >= n) ? 0 : n - 1 - k;
            end
            return 1'b1;
        endfunction

        // True when a read of (col, row) would fetch a pixel never written.
        function bit touches_unwritten(int col, int row, output int ci, output int ri);
            int w;
            int h;
            int p;
            bit okc;
            bit okr;
            w = interior_w();
            h = interior_h();
            p = border();
            ci = 0;
            ri = 0;
            if (col >= w + 2 * p || row >= h + 2 * p) return 1'b0;
            okc = fold(col, w, p, ci);
            okr = fold(row, h, p, ri);
            return okc && okr && !written[ri * MAX_WIDTH + ci];
        endfunction

        function void note_command(cmd_t cmd, logic [7:0] col, logic [7:0] row,
                                   logic [31:0] pix);
            int            w;
            int            h;
            int            p;
            int            ci;
            int            ri;
            bit            okc;
            bit            okr;
            fetch_result_t res;
            w = interior_w();
            h = interior_h();
            p = border();
            res.pixel  = '0;
            res.status = 1'b0;
            if (cmd == CMD_WRITE) begin
                if (col < w && row < h) begin
                    plane[row * MAX_WIDTH + col]   = pix;
                    written[row * MAX_WIDTH + col] = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end else if (col >= w + 2 * p || row >= h + 2 * p) begin
                res.status = 1'b1;
            end else begin
                okc = fold(col, w, p, ci);
                okr = fold(row, h, p, ri);
                if (okc && okr) res.pixel = plane[ri * MAX_WIDTH + ci];
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [31:0] pix, logic st);
            fetch_result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word, pixel %h status %b", $time, pix, st);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (pix !== exp_res.pixel) begin
                $display("%0t: pixel expected %h actual %h", $time, exp_res.pixel, pix);
                errors++;
            end
            if (st !== exp_res.status) begin
                $display("%0t: status expected %b actual %b", $time, exp_res.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // column [7:0], row [15:8], pixel_in [47:16]
    logic        s_tuser;   // cmd [0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pixel_out [31:0]
    logic        m_tuser;   // status [0]

    pad_fetch_board board;
    bit sender_idles;
    bit sink_idles;
    int hold_cycles;

    int         cfg_w    [NUM_PHASES] = '{128, 1, 5, 8, 0, 128, 6, 2, 16, 255};
    int         cfg_h    [NUM_PHASES] = '{128, 1, 7, 4, 200, 1, 6, 9, 16, 3};
    int         cfg_p    [NUM_PHASES] = '{16, 16, 3, 16, 31, 0, 4, 5, 1, 12};
    logic [1:0] cfg_mode [NUM_PHASES] = '{PAD_FILL, PAD_REFL, PAD_REPL, PAD_REFL, MODE_UNDEF,
                                          PAD_REPL, PAD_FILL, PAD_REFL, PAD_REPL, PAD_REFL};

    image_border_pad_fetch u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    // Result side: random back-pressure plus an occasional long hold-off.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= !sink_idles || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(cmd_t cmd, logic [7:0] col, logic [7:0] row, logic [31:0] pix);
        while (sender_idles && $urandom_range(0, 99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pix, row, col};
        do @(posedge clk); while (!s_tready);
        board.note_command(cmd, col, row, pix);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Mostly in-plane reads and interior writes; a read that would hit an
    // unwritten pixel turns into a write of that pixel instead.
    task automatic send_random();
        int   pick;
        int   w;
        int   h;
        int   p;
        int   col;
        int   row;
        int   ci;
        int   ri;
        cmd_t cmd;
        w    = board.interior_w();
        h    = board.interior_h();
        p    = board.border();
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            cmd = CMD_WRITE;
            col = $urandom_range(0, w - 1);
            row = $urandom_range(0, h - 1);
        end
        else if (pick < 42)
        begin
            cmd = cmd_t'($urandom_range(0, 1));
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
        end
        else
        begin
            cmd = CMD_READ;
            col = $urandom_range(0, w + 2 * p - 1);
            row = $urandom_range(0, h + 2 * p - 1);
        end
        if (cmd == CMD_READ && board.touches_unwritten(col, row, ci, ri))
        begin
            cmd = CMD_WRITE;
            col = ci;
            row = ri;
        end
        send_word(cmd, col[7:0], row[7:0], rand_pixel());
    endtask

    initial
    begin
        board        = new();
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
        hold_cycles  = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_WRITE;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 3x2 interior, border 2, reflect.
        write_reg(REG_WIDTH, 32'd3);
        write_reg(REG_HEIGHT, 32'd2);
        write_reg(REG_PAD, 32'd2);
        write_reg(REG_MODE, {30'd0, PAD_REFL});
        send_word(CMD_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send_word(CMD_WRITE, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 8'd2, 8'd0, 32'hA5A5_A5A5);
        send_word(CMD_WRITE, 8'd0, 8'd1, 32'h5A5A_5A5A);
        send_word(CMD_WRITE, 8'd1, 8'd1, 32'h8000_0000);
        send_word(CMD_WRITE, 8'd2, 8'd1, 32'h0000_0001);
        // writes outside the interior store nothing
        send_word(CMD_WRITE, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_word(CMD_WRITE, 8'd3, 8'd0, 32'h1234_5678);
        send_word(CMD_WRITE, 8'd0, 8'd2, 32'h8765_4321);
        // corners, interior edges and points off the padded plane
        send_word(CMD_READ, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_word(CMD_READ, 8'd6, 8'd5, 32'h0);
        send_word(CMD_READ, 8'd2, 8'd2, 32'h0);
        send_word(CMD_READ, 8'd4, 8'd3, 32'h0);
        send_word(CMD_READ, 8'd1, 8'd0, 32'h0);
        send_word(CMD_READ, 8'd5, 8'd4, 32'h0);
        send_word(CMD_READ, 8'd7, 8'd0, 32'h0);
        send_word(CMD_READ, 8'd0, 8'd6, 32'h0);
        send_word(CMD_READ, 8'd255, 8'd255, 32'h0);
        send_word(CMD_READ, 8'd128, 8'd1, 32'h0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            sender_idles = (ph != 1 && ph != 3);
            sink_idles   = (ph != 1);
            write_reg(REG_WIDTH, cfg_w[ph]);
            write_reg(REG_HEIGHT, cfg_h[ph]);
            write_reg(REG_PAD, cfg_p[ph]);
            write_reg(REG_MODE, {30'd0, cfg_mode[ph]});
            // stall the result side long enough to back up the command stream
            if (ph == 3)
                hold_cycles = 300;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
            drain();
        end

        repeat (4) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ibpf_pkg.sv
hw/rtl/image_border_pad_fetch.sv
sim/tb.sv
